// ----- sv/baro_temp_compensation_macros.svh -----
// ----------------------------------------------------------------------------
// Barometric compensation assertion macros
// Shared assertion wrappers, compiled out when NO_ASSERTIONS is set.
// ----------------------------------------------------------------------------
`ifndef BARO_TEMP_COMPENSATION_MACROS_SVH
`define BARO_TEMP_COMPENSATION_MACROS_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define BTC_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("btc: same-cycle check failed");
// next-cycle implication
`define BTC_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("btc: next-cycle check failed");
`else
`define BTC_ASSERT_IMP(lbl, ante, cons)
`define BTC_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// ----- sv/btc_pkg.sv -----
// ----------------------------------------------------------------------------
// btc_pkg
// Types, constants and helper functions of the barometric compensation block.
// ----------------------------------------------------------------------------
package btc_pkg;

	localparam int WORD_W     = 64;
	localparam int HALF_W     = 32;
	localparam int CFG_IDX_W  = 3;
	localparam int DIV_CNT_W  = $clog2(WORD_W);
	localparam int MUL_STEP_W = 2;

	typedef logic [WORD_W-1:0] word_t;
	typedef logic [HALF_W-1:0] half_t;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_TEMP_TRIM    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PRESS_TRIM_A = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PRESS_TRIM_B = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_PRESS_TRIM_C = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_FORMULA_MODE = 3'd4;

	// operation codes
	localparam logic [1:0] FUNC_TEMP  = 2'd0;
	localparam logic [1:0] FUNC_PRESS = 2'd1;

	// multiplier steps
	localparam logic [MUL_STEP_W-1:0] MUL_LO_LO = 2'd0;
	localparam logic [MUL_STEP_W-1:0] MUL_LO_HI = 2'd1;
	localparam logic [MUL_STEP_W-1:0] MUL_HI_LO = 2'd2;

	localparam word_t T_OFFS_64  = 64'd128000;
	localparam half_t T_OFFS_32  = 32'd64000;
	localparam word_t P_BASE_64  = 64'd1048576;
	localparam half_t P_BASE_32  = 32'd1048576;
	localparam word_t P_SCALE    = 64'd3125;
	localparam word_t P_ONE_Q47  = 64'h0000_8000_0000_0000;
	localparam half_t P_ONE_Q15  = 32'd32768;
	localparam word_t T_ROUND    = 64'd128;
	localparam logic signed [WORD_W-1:0] TEMP_HI = 64'sd1048575;
	localparam logic signed [WORD_W-1:0] TEMP_LO = -64'sd1048576;

	typedef enum logic [5:0] {
		ST_IDLE,
		ST_T_MUL1, ST_T_MUL2, ST_T_MUL3, ST_T_SAT,
		ST_A_INIT, ST_A_SQ, ST_A_V2A, ST_A_V2B, ST_A_V1A, ST_A_V1B, ST_A_V1C,
		ST_A_CHK, ST_A_NUM, ST_A_DIV, ST_A_R1, ST_A_R2, ST_A_R3, ST_A_FIN,
		ST_B_INIT, ST_B_SQ, ST_B_V2A, ST_B_V2B, ST_B_V1A, ST_B_V1B, ST_B_V1C,
		ST_B_CHK, ST_B_NUM, ST_B_DIV, ST_B_R1, ST_B_R2, ST_B_R3, ST_B_FIN,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic start;
		logic sgn;
	} div_ctl_t;

	function automatic word_t sx16(logic [15:0] v);
		return {{(WORD_W-16){v[15]}}, v};
	endfunction

	function automatic word_t sx32(half_t v);
		return {{(WORD_W-HALF_W){v[HALF_W-1]}}, v};
	endfunction

	function automatic word_t zx32(half_t v);
		return {{(WORD_W-HALF_W){1'b0}}, v};
	endfunction

	function automatic word_t asr64(word_t v, int unsigned s);
		return word_t'($signed(v) >>> s);
	endfunction

	function automatic half_t asr32(half_t v, int unsigned s);
		return half_t'($signed(v) >>> s);
	endfunction

endpackage

// ----- sv/btc_mul.sv -----
// ----------------------------------------------------------------------------
// btc_mul
// 64 x 64 multiplier, product modulo 2^64, built from one 32 x 32 unit that
// forms the low-low, low-high and high-low partial products in turn.
// ----------------------------------------------------------------------------
module btc_mul import btc_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	input  word_t a,
	input  word_t b,
	output logic  done,
	output word_t prod
);

	logic                  busy_q;
	logic                  done_q;
	logic [MUL_STEP_W-1:0] step_q;
	word_t                 a_q;
	word_t                 b_q;
	word_t                 acc_q;
	half_t                 mx;
	half_t                 my;
	word_t                 pp;

	always_comb begin
		case (step_q)
			MUL_LO_LO: begin
				mx = a_q[HALF_W-1:0];
				my = b_q[HALF_W-1:0];
			end
			MUL_LO_HI: begin
				mx = a_q[HALF_W-1:0];
				my = b_q[WORD_W-1:HALF_W];
			end
			default: begin
				mx = a_q[WORD_W-1:HALF_W];
				my = b_q[HALF_W-1:0];
			end
		endcase
		pp = word_t'(mx) * word_t'(my);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= MUL_LO_LO;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			step_q <= MUL_LO_LO;
		end else if (busy_q) begin
			step_q <= step_q + 1'b1;
			if (step_q == MUL_HI_LO) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			b_q <= b;
		end else if (busy_q) begin
			if (step_q == MUL_LO_LO) begin
				acc_q <= pp;
			end else begin
				acc_q <= acc_q + {pp[HALF_W-1:0], {HALF_W{1'b0}}};
			end
		end
	end

	assign done = done_q;
	assign prod = acc_q;

endmodule

// ----- sv/btc_div.sv -----
// ----------------------------------------------------------------------------
// btc_div
// 64-bit restoring divider, one quotient bit per cycle, signed or unsigned,
// quotient truncated toward zero.
// ----------------------------------------------------------------------------
module btc_div import btc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_ctl_t ctl,
	input  word_t    num,
	input  word_t    den,
	output logic     done,
	output word_t    quot
);

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 neg_q;
	word_t                rem_q;
	word_t                quo_q;
	word_t                den_q;
	logic [WORD_W:0]      sh;
	logic                 fits;

	assign sh   = {rem_q, quo_q[WORD_W-1]};
	assign fits = (sh >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (ctl.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == DIV_CNT_W'(WORD_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			rem_q <= '0;
			quo_q <= (ctl.sgn && num[WORD_W-1]) ? (word_t'(0) - num) : num;
			den_q <= (ctl.sgn && den[WORD_W-1]) ? (word_t'(0) - den) : den;
			neg_q <= ctl.sgn && (num[WORD_W-1] ^ den[WORD_W-1]);
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= WORD_W'(sh - {1'b0, den_q});
			end else begin
				rem_q <= sh[WORD_W-1:0];
			end
			quo_q <= {quo_q[WORD_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign quot = neg_q ? (word_t'(0) - quo_q) : quo_q;

endmodule

// ----- sv/baro_temp_compensation.sv -----
// ----------------------------------------------------------------------------
// baro_temp_compensation
// Integer temperature and pressure compensation for a barometric sensor.
// ----------------------------------------------------------------------------
// One word on the input channel carries an operation code and the raw 20-bit
// temperature and pressure readings; one word comes back for each. Code 0
// runs the temperature polynomial only, code 1 runs pressure only with the
// fine temperature kept from the last temperature run, codes 2 and 3 run
// both. A field that was not recomputed repeats its last value, and
// divisor_zero rises (with pressure forced to 0) when the pressure divisor
// comes out zero. The sequenced multiplies and the divide go through
// one shared 64 x 64 multiplier (a single 32 x 32 unit used in turn) and one
// restoring divider (one bit per cycle). The temperature part uses three
// multiplies; pressure adds ten multiplies and one divide, in either
// formula, and skips the divide when the divisor is zero. The block takes
// one word at a time: in_ready is high only while the sequencer is idle. A
// finished result sits in an output register, so the next word may enter
// while it waits to be taken. Write the calibration registers only while the
// block is idle.
// ----------------------------------------------------------------------------
`include "baro_temp_compensation_macros.svh"

module baro_temp_compensation import btc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [WORD_W-1:0]    cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [1:0]           func,
	input  logic [19:0]          adc_t,
	input  logic [19:0]          adc_p,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic signed [20:0]   temperature_centi,
	output logic [31:0]          pressure,
	output logic                 divisor_zero
);

	// calibration registers
	logic [47:0] temp_trim_q;
	word_t       press_a_q;
	word_t       press_b_q;
	logic [15:0] press_c_q;
	logic        mode_q;

	// word under work
	logic [1:0]  func_q;
	logic [19:0] adc_t_q;
	logic [19:0] adc_p_q;

	// kept state
	half_t       fine_q;
	logic [20:0] last_temp_q;
	half_t       last_press_q;
	logic        dz_q;

	// scratch registers of the sequencer
	word_t       ra_q;
	word_t       rb_q;
	word_t       rc_q;
	word_t       rd_q;
	logic        wait_q;

	// output register
	logic        out_valid_q;
	logic [20:0] out_temp_q;
	half_t       out_press_q;
	logic        out_dz_q;

	state_t      state_q;
	state_t      state_d;
	state_t      press_entry;

	// shared units
	logic        mul_state;
	logic        mul_start;
	word_t       mul_a;
	word_t       mul_b;
	logic        mul_done;
	word_t       prod;
	half_t       prod32;
	div_ctl_t    div_ctl;
	word_t       div_num;
	word_t       div_den;
	logic        div_done;
	word_t       quot;
	logic        out_load;

	// calibration words
	word_t t1, t2, t3;
	word_t p1, p2, p3, p4, p5, p6, p7, p8, p9;

	// datapath helpers
	word_t d1, d2;
	word_t fine_sx;
	word_t a64;
	half_t a32;
	word_t p64;
	word_t tw;
	word_t tc;
	logic [20:0] tc_sat;
	half_t q32;
	half_t num32;

	assign t1 = {48'b0, temp_trim_q[15:0]};
	assign t2 = sx16(temp_trim_q[31:16]);
	assign t3 = sx16(temp_trim_q[47:32]);
	assign p1 = {48'b0, press_a_q[15:0]};
	assign p2 = sx16(press_a_q[31:16]);
	assign p3 = sx16(press_a_q[47:32]);
	assign p4 = sx16(press_a_q[63:48]);
	assign p5 = sx16(press_b_q[15:0]);
	assign p6 = sx16(press_b_q[31:16]);
	assign p7 = sx16(press_b_q[47:32]);
	assign p8 = sx16(press_b_q[63:48]);
	assign p9 = sx16(press_c_q);

	assign d1      = word_t'(adc_t_q >> 3) - (t1 << 1);
	assign d2      = word_t'(adc_t_q >> 4) - t1;
	assign fine_sx = sx32(fine_q);
	assign a64     = fine_sx - T_OFFS_64;
	assign a32     = asr32(fine_q, 1) - T_OFFS_32;
	assign p64     = P_BASE_64 - word_t'(adc_p_q);
	assign q32     = asr32(rc_q[HALF_W-1:0], 2);
	assign num32   = (P_BASE_32 - half_t'(adc_p_q)) - asr32(ra_q[HALF_W-1:0], 12);
	assign prod32  = prod[HALF_W-1:0];

	// temperature in hundredths: (fine * 5 + 128) >> 8, then saturate
	assign tw = (fine_sx << 2) + fine_sx + T_ROUND;
	assign tc = asr64(tw, 8);
	always_comb begin
		if ($signed(tc) > TEMP_HI) begin
			tc_sat = TEMP_HI[20:0];
		end else if ($signed(tc) < TEMP_LO) begin
			tc_sat = TEMP_LO[20:0];
		end else begin
			tc_sat = tc[20:0];
		end
	end

	assign press_entry = mode_q ? ST_B_INIT : ST_A_INIT;

	// ------------------------------------------------------------------
	// Next state
	// ------------------------------------------------------------------
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = (func != FUNC_PRESS) ? ST_T_MUL1 : press_entry;
				end
			end
			ST_T_MUL1: if (mul_done) state_d = ST_T_MUL2;
			ST_T_MUL2: if (mul_done) state_d = ST_T_MUL3;
			ST_T_MUL3: if (mul_done) state_d = ST_T_SAT;
			ST_T_SAT:  state_d = (func_q == FUNC_TEMP) ? ST_DONE : press_entry;
			ST_A_INIT: state_d = ST_A_SQ;
			ST_A_SQ:   if (mul_done) state_d = ST_A_V2A;
			ST_A_V2A:  if (mul_done) state_d = ST_A_V2B;
			ST_A_V2B:  if (mul_done) state_d = ST_A_V1A;
			ST_A_V1A:  if (mul_done) state_d = ST_A_V1B;
			ST_A_V1B:  if (mul_done) state_d = ST_A_V1C;
			ST_A_V1C:  if (mul_done) state_d = ST_A_CHK;
			ST_A_CHK:  state_d = (rb_q == '0) ? ST_DONE : ST_A_NUM;
			ST_A_NUM:  if (mul_done) state_d = ST_A_DIV;
			ST_A_DIV:  if (div_done) state_d = ST_A_R1;
			ST_A_R1:   if (mul_done) state_d = ST_A_R2;
			ST_A_R2:   if (mul_done) state_d = ST_A_R3;
			ST_A_R3:   if (mul_done) state_d = ST_A_FIN;
			ST_A_FIN:  state_d = ST_DONE;
			ST_B_INIT: state_d = ST_B_SQ;
			ST_B_SQ:   if (mul_done) state_d = ST_B_V2A;
			ST_B_V2A:  if (mul_done) state_d = ST_B_V2B;
			ST_B_V2B:  if (mul_done) state_d = ST_B_V1A;
			ST_B_V1A:  if (mul_done) state_d = ST_B_V1B;
			ST_B_V1B:  if (mul_done) state_d = ST_B_V1C;
			ST_B_V1C:  if (mul_done) state_d = ST_B_CHK;
			ST_B_CHK:  state_d = (rb_q[HALF_W-1:0] == '0) ? ST_DONE : ST_B_NUM;
			ST_B_NUM:  if (mul_done) state_d = ST_B_DIV;
			ST_B_DIV:  if (div_done) state_d = ST_B_R1;
			ST_B_R1:   if (mul_done) state_d = ST_B_R2;
			ST_B_R2:   if (mul_done) state_d = ST_B_R3;
			ST_B_R3:   if (mul_done) state_d = ST_B_FIN;
			ST_B_FIN:  state_d = ST_DONE;
			ST_DONE:   if (!out_valid_q || out_ready) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// ------------------------------------------------------------------
	// Sequencer outputs: operand select for the shared units
	// ------------------------------------------------------------------
	always_comb begin
		mul_state = 1'b1;
		mul_a     = '0;
		mul_b     = '0;
		unique case (state_q)
			ST_T_MUL1: begin mul_a = d1;   mul_b = t2; end
			ST_T_MUL2: begin mul_a = d2;   mul_b = d2; end
			ST_T_MUL3: begin mul_a = rb_q; mul_b = t3; end
			ST_A_SQ:   begin mul_a = rc_q; mul_b = rc_q; end
			ST_A_V2A:  begin mul_a = rd_q; mul_b = p6; end
			ST_A_V2B:  begin mul_a = rc_q; mul_b = p5; end
			ST_A_V1A:  begin mul_a = rd_q; mul_b = p3; end
			ST_A_V1B:  begin mul_a = rc_q; mul_b = p2; end
			ST_A_V1C:  begin mul_a = rb_q + P_ONE_Q47; mul_b = p1; end
			ST_A_NUM:  begin mul_a = (p64 << 31) - ra_q; mul_b = P_SCALE; end
			ST_A_R1:   begin mul_a = p9;   mul_b = asr64(rc_q, 13); end
			ST_A_R2:   begin mul_a = ra_q; mul_b = asr64(rc_q, 13); end
			ST_A_R3:   begin mul_a = p8;   mul_b = rc_q; end
			ST_B_SQ:   begin mul_a = zx32(q32); mul_b = zx32(q32); end
			ST_B_V2A: begin
				mul_a = zx32(asr32(rd_q[HALF_W-1:0], 11));
				mul_b = p6;
			end
			ST_B_V2B:  begin mul_a = rc_q; mul_b = p5; end
			ST_B_V1A: begin
				mul_a = p3;
				mul_b = zx32(asr32(rd_q[HALF_W-1:0], 13));
			end
			ST_B_V1B:  begin mul_a = p2;   mul_b = rc_q; end
			ST_B_V1C: begin
				mul_a = zx32(P_ONE_Q15 + rb_q[HALF_W-1:0]);
				mul_b = p1;
			end
			ST_B_NUM:  begin mul_a = zx32(num32); mul_b = P_SCALE; end
			ST_B_R1: begin
				mul_a = zx32(rc_q[HALF_W-1:0] >> 3);
				mul_b = zx32(rc_q[HALF_W-1:0] >> 3);
			end
			ST_B_R2:   begin mul_a = p9;   mul_b = ra_q; end
			ST_B_R3:   begin mul_a = zx32(rc_q[HALF_W-1:0] >> 2); mul_b = p8; end
			default:   mul_state = 1'b0;
		endcase
	end

	always_comb begin
		in_ready      = (state_q == ST_IDLE);
		mul_start     = mul_state && !wait_q;
		div_ctl.start = (state_q == ST_A_DIV || state_q == ST_B_DIV) && !wait_q;
		div_ctl.sgn   = (state_q == ST_A_DIV);
		out_load      = (state_q == ST_DONE) && (!out_valid_q || out_ready);
		if (state_q == ST_A_DIV) begin
			div_num = rc_q;
			div_den = rb_q;
		end else begin
			// 32-bit formula: double before the divide unless that overflows
			div_num = rc_q[HALF_W-1] ? zx32(rc_q[HALF_W-1:0])
			                         : zx32({rc_q[HALF_W-2:0], 1'b0});
			div_den = zx32(rb_q[HALF_W-1:0]);
		end
	end

	btc_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.prod   (prod)
	);

	btc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (div_ctl),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quot   (quot)
	);

	// ------------------------------------------------------------------
	// Control, configuration and kept state
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			wait_q       <= 1'b0;
			temp_trim_q  <= '0;
			press_a_q    <= '0;
			press_b_q    <= '0;
			press_c_q    <= '0;
			mode_q       <= 1'b0;
			fine_q       <= '0;
			last_temp_q  <= '0;
			last_press_q <= '0;
			dz_q         <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;

			// hold while a unit works, drop on its done
			if (mul_start || div_ctl.start) begin
				wait_q <= 1'b1;
			end else if (mul_done || div_done) begin
				wait_q <= 1'b0;
			end

			if (cfg_we) begin
				unique case (cfg_index)
					CFG_TEMP_TRIM:    temp_trim_q <= cfg_data[47:0];
					CFG_PRESS_TRIM_A: press_a_q   <= cfg_data;
					CFG_PRESS_TRIM_B: press_b_q   <= cfg_data;
					CFG_PRESS_TRIM_C: press_c_q   <= cfg_data[15:0];
					CFG_FORMULA_MODE: mode_q      <= cfg_data[0];
					default: ;
				endcase
			end

			if (in_valid && in_ready) begin
				dz_q <= 1'b0;
			end

			if (state_q == ST_T_MUL3 && mul_done) begin
				fine_q <= half_t'(ra_q + asr64(prod, 14));
			end
			if (state_q == ST_T_SAT) begin
				last_temp_q <= tc_sat;
			end
			if ((state_q == ST_A_CHK && rb_q == '0) ||
			    (state_q == ST_B_CHK && rb_q[HALF_W-1:0] == '0)) begin
				last_press_q <= '0;
				dz_q         <= 1'b1;
			end
			if (state_q == ST_A_FIN) begin
				last_press_q <= half_t'(asr64(rc_q + ra_q + rb_q, 8) + (p7 << 4));
			end
			if (state_q == ST_B_FIN) begin
				last_press_q <= rc_q[HALF_W-1:0] + asr32(ra_q[HALF_W-1:0] +
				                rb_q[HALF_W-1:0] + p7[HALF_W-1:0], 4);
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Word and scratch registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			func_q  <= func;
			adc_t_q <= adc_t;
			adc_p_q <= adc_p;
		end

		if (out_load) begin
			out_temp_q  <= last_temp_q;
			out_press_q <= last_press_q;
			out_dz_q    <= dz_q;
		end

		if (state_q == ST_A_INIT) begin
			rc_q <= a64;
		end
		if (state_q == ST_B_INIT) begin
			rc_q <= zx32(a32);
		end
		if (state_q == ST_A_DIV && div_done) begin
			rc_q <= quot;
		end
		if (state_q == ST_B_DIV && div_done) begin
			rc_q <= rc_q[HALF_W-1] ? zx32({quot[HALF_W-2:0], 1'b0})
			                       : zx32(quot[HALF_W-1:0]);
		end

		if (mul_done) begin
			case (state_q)
				ST_T_MUL1: ra_q <= asr64(prod, 11);
				ST_T_MUL2: rb_q <= asr64(prod, 12);
				ST_A_SQ:   rd_q <= prod;
				ST_A_V2A:  ra_q <= prod;
				ST_A_V2B:  ra_q <= ra_q + (prod << 17) + (p4 << 35);
				ST_A_V1A:  rb_q <= asr64(prod, 8);
				ST_A_V1B:  rb_q <= rb_q + (prod << 12);
				ST_A_V1C:  rb_q <= asr64(prod, 33);
				ST_A_NUM:  rc_q <= prod;
				ST_A_R1:   ra_q <= prod;
				ST_A_R2:   ra_q <= asr64(prod, 25);
				ST_A_R3:   rb_q <= asr64(prod, 19);
				ST_B_SQ:   rd_q <= zx32(prod32);
				ST_B_V2A:  ra_q <= zx32(prod32);
				ST_B_V2B: begin
					ra_q <= zx32(asr32(ra_q[HALF_W-1:0] + (prod32 << 1), 2) +
					             (p4[HALF_W-1:0] << 16));
				end
				ST_B_V1A:  rb_q <= zx32(asr32(prod32, 3));
				ST_B_V1B: begin
					rb_q <= zx32(asr32(rb_q[HALF_W-1:0] + asr32(prod32, 1), 18));
				end
				ST_B_V1C:  rb_q <= zx32(asr32(prod32, 15));
				ST_B_NUM:  rc_q <= zx32(prod32);
				ST_B_R1:   ra_q <= zx32(prod32 >> 13);
				ST_B_R2:   ra_q <= zx32(asr32(prod32, 12));
				ST_B_R3:   rb_q <= zx32(asr32(prod32, 13));
				default: ;
			endcase
		end
	end

	assign out_valid         = out_valid_q;
	assign temperature_centi = out_temp_q;
	assign pressure          = out_press_q;
	assign divisor_zero      = out_dz_q;

	// ------------------------------------------------------------------
	// Checks
	// ------------------------------------------------------------------
	`BTC_ASSERT_NXT(a_accept_leaves_idle, in_valid && in_ready, state_q != ST_IDLE)
	`BTC_ASSERT_IMP(a_mul_done_awaited, mul_done, wait_q && mul_state)
	`BTC_ASSERT_IMP(a_div_done_awaited, div_done, state_q == ST_A_DIV || state_q == ST_B_DIV)
	`BTC_ASSERT_IMP(a_zero_div_zero_press, out_valid && divisor_zero, pressure == 32'd0)

endmodule

// ----- bench/tb_baro_temp_compensation.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_baro_temp_compensation
// Self-checking bench for the barometric compensation block: a directed table
// followed by random words, each result compared with a value from the table
// or from an in-bench model of the integer temperature and pressure polynomials.
// ----------------------------------------------------------------------------
module tb_baro_temp_compensation import btc_pkg::*;;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int DRAIN_CYCLES   = 300;
	localparam int HOLD_CYCLES    = 3000;
	localparam int RAND_WORDS     = 1530;
	localparam int N_DIR          = 20;

	// calibration sets used by the directed table
	localparam int SET_RESET  = 0;
	localparam int SET_TYP64  = 1;
	localparam int SET_TYP32  = 2;
	localparam int SET_ONES   = 3;
	localparam int SET_ZERO32 = 4;

	// operation codes beyond the two the package names
	localparam logic [1:0] FUNC_BOTH   = 2'd2;
	localparam logic [1:0] FUNC_UNUSED = 2'd3;

	// typical calibration words of a real part
	localparam logic [63:0] TYP_TEMP = 64'h0000_FC18_6743_6B70;
	localparam logic [63:0] TYP_PA   = 64'h0B27_0BD0_D643_8E7D;
	localparam logic [63:0] TYP_PB   = 64'hC6F8_3C8C_FFF9_008C;
	localparam logic [63:0] TYP_PC   = 64'h0000_0000_0000_1770;

	typedef struct packed {
		logic [20:0] temp;
		logic [31:0] press;
		logic        dz;
	} result_t;

	typedef struct {
		int          set_id;
		logic [1:0]  op;
		logic [19:0] raw_t;
		logic [19:0] raw_p;
		bit          typed;
		result_t     res;
	} dir_row_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [WORD_W-1:0]    cfg_data = '0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic [1:0]           func = '0;
	logic [19:0]          adc_t = '0;
	logic [19:0]          adc_p = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic signed [20:0]   temperature_centi;
	logic [31:0]          pressure;
	logic                 divisor_zero;

	baro_temp_compensation dut (.*);

	always #10 clk = ~clk;

	// shadow of the calibration registers and of the block's state
	logic [47:0] trim_t;
	logic [63:0] trim_pa, trim_pb;
	logic [15:0] trim_pc;
	logic        mode32;
	logic [31:0] fine_t;
	logic [20:0] held_temp;
	logic [31:0] held_press;

	result_t expected_q[$];
	int      mismatches = 0;
	int      send_idle = 0, recv_idle = 0;
	int      hold_req = 0;
	int      stalled = 0;

	// --------------------------------------------------------------------
	// arithmetic helpers
	// --------------------------------------------------------------------
	function automatic logic [63:0] shr_s64(logic [63:0] v, int s);
		return $signed(v) >>> s;
	endfunction

	function automatic logic [31:0] shr_s32(logic [31:0] v, int s);
		return $signed(v) >>> s;
	endfunction

	function automatic logic [63:0] ext16(logic [15:0] v);
		return {{48{v[15]}}, v};
	endfunction

	// truncating signed divide, most negative / -1 wraps to itself
	function automatic logic [63:0] div_trunc(logic [63:0] n, logic [63:0] d);
		logic [63:0] an, ad, q;
		an = n[63] ? -n : n;
		ad = d[63] ? -d : d;
		q = an / ad;
		return (n[63] != d[63]) ? -q : q;
	endfunction

	// temperature polynomial: update fine temperature and held temperature
	function automatic void calc_temperature(logic [19:0] raw);
		logic [63:0] t1, t2, t3, d1, d2, a, b, raw64;
		logic signed [63:0] c;
		raw64 = {44'd0, raw};
		t1 = {48'd0, trim_t[15:0]};
		t2 = ext16(trim_t[31:16]);
		t3 = ext16(trim_t[47:32]);
		d1 = (raw64 >> 3) - (t1 << 1);
		a = shr_s64(d1 * t2, 11);
		d2 = (raw64 >> 4) - t1;
		b = shr_s64(shr_s64(d2 * d2, 12) * t3, 14);
		fine_t = a[31:0] + b[31:0];
		c = $signed(shr_s64({{32{fine_t[31]}}, fine_t} * 64'd5 + 64'd128, 8));
		if (c > 64'sd1048575)
			c = 64'sd1048575;
		if (c < -64'sd1048576)
			c = -64'sd1048576;
		held_temp = c[20:0];
	endfunction

	// 64-bit formula, Q24.8 result; 0 when the divisor vanishes
	function automatic bit calc_press_wide(logic [19:0] raw, output logic [31:0] res);
		logic [63:0] v1, v2, p, n;
		v1 = {{32{fine_t[31]}}, fine_t} - 64'd128000;
		v2 = v1 * v1 * ext16(trim_pb[31:16]);
		v2 = v2 + ((v1 * ext16(trim_pb[15:0])) << 17);
		v2 = v2 + (ext16(trim_pa[63:48]) << 35);
		v1 = shr_s64(v1 * v1 * ext16(trim_pa[47:32]), 8)
			+ ((v1 * ext16(trim_pa[31:16])) << 12);
		v1 = shr_s64((64'h0000_8000_0000_0000 + v1) * {48'd0, trim_pa[15:0]}, 33);
		res = '0;
		if (v1 == 0)
			return 1'b0;
		p = 64'd1048576 - {44'd0, raw};
		n = ((p << 31) - v2) * 64'd3125;
		p = div_trunc(n, v1);
		v1 = shr_s64(ext16(trim_pc) * shr_s64(p, 13) * shr_s64(p, 13), 25);
		v2 = shr_s64(ext16(trim_pb[63:48]) * p, 19);
		p = shr_s64(p + v1 + v2, 8) + (ext16(trim_pb[47:32]) << 4);
		res = p[31:0];
		return 1'b1;
	endfunction

	// 32-bit formula, whole pascals; 0 when the divisor vanishes
	function automatic bit calc_press_narrow(logic [19:0] raw, output logic [31:0] res);
		logic [31:0] a, q, sq, v1, v2, p, t, w_a1, w_a2, w_a3, w_b0, w_b1, w_b2, w_b3, w_c;
		w_a1 = 32'(ext16(trim_pa[31:16]));
		w_a2 = 32'(ext16(trim_pa[47:32]));
		w_a3 = 32'(ext16(trim_pa[63:48]));
		w_b0 = 32'(ext16(trim_pb[15:0]));
		w_b1 = 32'(ext16(trim_pb[31:16]));
		w_b2 = 32'(ext16(trim_pb[47:32]));
		w_b3 = 32'(ext16(trim_pb[63:48]));
		w_c  = 32'(ext16(trim_pc));
		a = shr_s32(fine_t, 1) - 32'd64000;
		q = shr_s32(a, 2);
		sq = q * q;
		v2 = shr_s32(sq, 11) * w_b1;
		t = a * w_b0;
		v2 = v2 + (t << 1);
		v2 = shr_s32(v2, 2) + (w_a3 << 16);
		t = w_a2 * shr_s32(sq, 13);
		v1 = w_a1 * a;
		v1 = shr_s32(shr_s32(t, 3) + shr_s32(v1, 1), 18);
		v1 = (32'd32768 + v1) * {16'd0, trim_pa[15:0]};
		v1 = shr_s32(v1, 15);
		res = '0;
		if (v1 == 0)
			return 1'b0;
		p = ((32'd1048576 - {12'd0, raw}) - shr_s32(v2, 12)) * 32'd3125;
		if (p < 32'h8000_0000)
			p = (p << 1) / v1;
		else
			p = (p / v1) * 32'd2;
		t = (p >> 3) * (p >> 3);
		t = t >> 13;
		v1 = shr_s32(w_c * t, 12);
		t = (p >> 2) * w_b3;
		v2 = shr_s32(t, 13);
		p = p + shr_s32(v1 + v2 + w_b2, 4);
		res = p;
		return 1'b1;
	endfunction

	// advance the state for one accepted word and return its result
	function automatic result_t compensate(logic [1:0] op, logic [19:0] rt, logic [19:0] rp);
		result_t r;
		logic [31:0] pv;
		bit ok;
		r.dz = 1'b0;
		if (op != FUNC_PRESS)
			calc_temperature(rt);
		if (op != FUNC_TEMP) begin
			ok = mode32 ? calc_press_narrow(rp, pv) : calc_press_wide(rp, pv);
			if (!ok) begin
				pv = '0;
				r.dz = 1'b1;
			end
			held_press = pv;
		end
		r.temp = held_temp;
		r.press = held_press;
		return r;
	endfunction

	// --------------------------------------------------------------------
	// receiver: random stalls plus an occasional long hold-off
	// --------------------------------------------------------------------
	int hold_left = 0;
	always @(negedge clk) begin
		if (hold_req != 0) begin
			hold_left = hold_req;
			hold_req = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle);
		end
	end

	// --------------------------------------------------------------------
	// result check and watchdog, sampled at the rising edge
	// --------------------------------------------------------------------
	always @(posedge clk) begin
		result_t exp_r;
		if (arst_n && out_valid && out_ready) begin
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected word: temp %0d press %h dz %b",
						temperature_centi, pressure, divisor_zero);
			end else begin
				exp_r = expected_q.pop_front();
				if (temperature_centi !== exp_r.temp || pressure !== exp_r.press ||
						divisor_zero !== exp_r.dz) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: temp %0d/%0d press %h/%h dz %b/%b (exp/act)",
							$signed(exp_r.temp), temperature_centi, exp_r.press,
							pressure, exp_r.dz, divisor_zero);
				end
			end
		end
		// count cycles where neither channel moves a word
		if ((in_valid && in_ready) || (out_valid && out_ready))
			stalled = 0;
		else
			stalled++;
		if (stalled >= WATCHDOG_LIMIT) begin
			$display("tb_baro_temp_compensation failed");
			$finish;
		end
	end

	// --------------------------------------------------------------------
	// configuration and stimulus
	// --------------------------------------------------------------------
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			CFG_TEMP_TRIM:    trim_t = val[47:0];
			CFG_PRESS_TRIM_A: trim_pa = val;
			CFG_PRESS_TRIM_B: trim_pb = val;
			CFG_PRESS_TRIM_C: trim_pc = val[15:0];
			CFG_FORMULA_MODE: mode32 = val[0];
			default: ;
		endcase
	endtask

	// wait for the block to go quiet, then load a full calibration set
	task automatic load_cal(logic [63:0] tt, logic [63:0] pa, logic [63:0] pb,
			logic [63:0] pc, logic [63:0] md);
		while (expected_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		write_reg(CFG_TEMP_TRIM, tt);
		write_reg(CFG_PRESS_TRIM_A, pa);
		write_reg(CFG_PRESS_TRIM_B, pb);
		write_reg(CFG_PRESS_TRIM_C, pc);
		write_reg(CFG_FORMULA_MODE, md);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic load_set(int id);
		case (id)
			SET_TYP64:  load_cal(TYP_TEMP, TYP_PA, TYP_PB, TYP_PC, 64'd0);
			SET_TYP32:  load_cal(TYP_TEMP, TYP_PA, TYP_PB, TYP_PC, 64'd1);
			SET_ONES:   load_cal('1, '1, '1, '1, '1);
			SET_ZERO32: load_cal('0, '0, '0, '0, 64'd1);
			default: ;
		endcase
	endtask

	// random calibration: mostly near a real part, sometimes anything
	task automatic load_random_cal();
		logic [63:0] tt, pa, pb, pc;
		if ($urandom_range(99) < 60) begin
			tt = TYP_TEMP ^ {16'd0, 8'd0, 8'($urandom), 8'd0, 8'($urandom), 8'd0, 8'($urandom)};
			pa = TYP_PA ^ {8'd0, 8'($urandom), 8'd0, 8'($urandom),
				8'd0, 8'($urandom), 8'd0, 8'($urandom)};
			pb = TYP_PB ^ {8'd0, 8'($urandom), 8'd0, 8'($urandom),
				8'd0, 8'($urandom), 8'd0, 8'($urandom)};
			pc = TYP_PC ^ {56'd0, 8'($urandom)};
		end else begin
			tt = {$urandom, $urandom};
			pa = {$urandom, $urandom};
			pb = {$urandom, $urandom};
			pc = {$urandom, $urandom};
		end
		load_cal(tt, pa, pb, pc, {$urandom, $urandom});
	endtask

	// offer one word, hold it until taken, then predict its result
	task automatic send_word(logic [1:0] op, logic [19:0] rt, logic [19:0] rp,
			bit typed, result_t typed_res);
		result_t r;
		@(negedge clk);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		func <= op;
		adc_t <= rt;
		adc_p <= rp;
		do
			@(posedge clk);
		while (!in_ready);
		r = compensate(op, rt, rp);
		expected_q.push_back(typed ? typed_res : r);
	endtask

	dir_row_t dir_tab[N_DIR];

	initial begin
		int cur_set;
		logic [1:0] op;
		logic [19:0] rt, rp;
		trim_t = '0;
		trim_pa = '0;
		trim_pb = '0;
		trim_pc = '0;
		mode32 = 1'b0;
		fine_t = '0;
		held_temp = '0;
		held_press = '0;
		// after reset every trim is zero: temperature 0, pressure divisor zero
		dir_tab = '{
			'{SET_RESET, FUNC_BOTH, 20'h00000, 20'h00000, 1, '{21'd0, 32'd0, 1'b1}},
			'{SET_RESET, FUNC_TEMP, 20'hFFFFF, 20'hFFFFF, 1, '{21'd0, 32'd0, 1'b0}},
			'{SET_RESET, FUNC_PRESS, 20'hFFFFF, 20'h00000, 1, '{21'd0, 32'd0, 1'b1}},
			'{SET_RESET, FUNC_UNUSED, 20'hFFFFF, 20'hFFFFF, 1, '{21'd0, 32'd0, 1'b1}},
			'{SET_TYP64, FUNC_PRESS, 20'd519888, 20'd415148, 0, '0},
			'{SET_TYP64, FUNC_TEMP, 20'd519888, 20'd415148, 0, '0},
			'{SET_TYP64, FUNC_PRESS, 20'd0, 20'd415148, 0, '0},
			'{SET_TYP64, FUNC_BOTH, 20'd519888, 20'd415148, 0, '0},
			'{SET_TYP64, FUNC_UNUSED, 20'hFFFFF, 20'h00000, 0, '0},
			'{SET_TYP64, FUNC_BOTH, 20'h00000, 20'hFFFFF, 0, '0},
			'{SET_TYP32, FUNC_BOTH, 20'd519888, 20'd415148, 0, '0},
			'{SET_TYP32, FUNC_TEMP, 20'h00000, 20'hFFFFF, 0, '0},
			'{SET_TYP32, FUNC_PRESS, 20'hFFFFF, 20'h00000, 0, '0},
			'{SET_TYP32, FUNC_UNUSED, 20'hFFFFF, 20'hFFFFF, 0, '0},
			'{SET_ONES, FUNC_BOTH, 20'h00000, 20'h00000, 0, '0},
			'{SET_ONES, FUNC_UNUSED, 20'hFFFFF, 20'hFFFFF, 0, '0},
			'{SET_ONES, FUNC_TEMP, 20'h55555, 20'hAAAAA, 0, '0},
			'{SET_ZERO32, FUNC_BOTH, 20'd0, 20'd0, 1, '{21'd0, 32'd0, 1'b1}},
			'{SET_ZERO32, FUNC_TEMP, 20'hFFFFF, 20'hFFFFF, 1, '{21'd0, 32'd0, 1'b0}},
			'{SET_ZERO32, FUNC_PRESS, 20'hAAAAA, 20'h55555, 1, '{21'd0, 32'd0, 1'b1}}
		};
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed table, reload calibration whenever the set changes
		cur_set = SET_RESET;
		foreach (dir_tab[i]) begin
			if (dir_tab[i].set_id != cur_set) begin
				// lower valid before going quiet for the register writes
				@(negedge clk);
				in_valid <= 1'b0;
				load_set(dir_tab[i].set_id);
				cur_set = dir_tab[i].set_id;
			end
			send_word(dir_tab[i].op, dir_tab[i].raw_t, dir_tab[i].raw_p,
				dir_tab[i].typed, dir_tab[i].res);
		end

		// random part: three idling regimes, each with fresh calibration twice
		for (int regime = 0; regime < 3; regime++) begin
			send_idle = (regime == 0) ? 37 : (regime == 1) ? 59 : 0;
			recv_idle = (regime == 0) ? 59 : (regime == 1) ? 37 : 0;
			for (int half = 0; half < 2; half++) begin
				@(negedge clk);
				in_valid <= 1'b0;
				load_random_cal();
				// block the result side long enough for the input to back up
				if (regime == 2 && half == 0)
					hold_req = HOLD_CYCLES;
				for (int n = 0; n < RAND_WORDS / 6; n++) begin
					op = 2'($urandom_range(3));
					if ($urandom_range(99) < 70) begin
						rt = 20'($urandom_range(600000, 400000));
						rp = 20'($urandom_range(500000, 250000));
					end else begin
						rt = 20'($urandom);
						rp = 20'($urandom);
					end
					send_word(op, rt, rp, 0, '0);
				end
			end
		end
		@(negedge clk);
		in_valid <= 1'b0;

		// drain, then let the pipeline settle before judging
		while (expected_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && expected_q.size() == 0)
			$display("tb_baro_temp_compensation passed");
		else
			$display("tb_baro_temp_compensation failed");
		$finish;
	end

endmodule
